// ----- rtl/core/mmrf_pkg.sv -----
package mmrf_pkg;

  // Frame bound: no reply byte is stored at this index or beyond.
  localparam int unsigned MAX_FRAME = 64;

  // Field widths.
  localparam int unsigned IDX_W  = 9;
  localparam int unsigned TICK_W = 16;

  localparam logic [IDX_W-1:0] MAX_FRAME_IDX = IDX_W'(MAX_FRAME);

  // Function codes of interest.
  localparam logic [7:0] FC_READ_HOLD   = 8'h03;
  localparam logic [7:0] FC_READ_INPUT  = 8'h04;
  localparam logic [7:0] FC_WRITE_MULTI = 8'h10;

  // Frame lengths.
  localparam logic [IDX_W-1:0] NEED_UNKNOWN    = 9'd255;
  localparam logic [IDX_W-1:0] WRITE_REPLY_LEN = 9'd8;
  localparam logic [IDX_W-1:0] READ_EXTRA_LEN  = 9'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_SLAVE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  // Input commands; the fourth code is unused and ignored.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_SEND    = 3'd1,
    ST_STORED  = 3'd2,
    ST_DONE    = 3'd3,
    ST_RESEND  = 3'd4,
    ST_FAILED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]        slave_address;
    logic [7:0]        retry_limit;
    logic [TICK_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              waiting;
    logic              frame_done;
    logic [IDX_W-1:0]  byte_count;
    logic [IDX_W-1:0]  needed_count;
    logic [7:0]        current_function;
    logic [TICK_W-1:0] elapsed_ticks;
    logic [7:0]        attempts_remaining;
  } state_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       byte_value;
    logic [7:0]       attempts_left;
  } result_t;

endpackage

// ----- rtl/core/mmrf_step.sv -----
module mmrf_step (
  input  mmrf_pkg::cfg_t   cfg,
  input  mmrf_pkg::state_t st,
  input  logic [1:0]       cmd,
  input  logic [7:0]       function_code,
  input  logic [7:0]       rx_byte,
  output mmrf_pkg::state_t st_next,
  output mmrf_pkg::result_t res
);

  logic [mmrf_pkg::IDX_W-1:0]  cnt_inc;
  logic [mmrf_pkg::IDX_W-1:0]  read_len;
  logic [mmrf_pkg::TICK_W-1:0] elapsed_inc;
  logic [7:0]                  attempts_dec;
  logic                        is_read;

  // Small arithmetic for the command arms.
  assign cnt_inc  = st.byte_count + 9'd1;
  assign read_len = 9'(rx_byte) + mmrf_pkg::READ_EXTRA_LEN;
  assign elapsed_inc = (st.elapsed_ticks == '1) ? st.elapsed_ticks
                                                : st.elapsed_ticks + 16'd1;
  assign attempts_dec = (st.attempts_remaining != 8'd0) ? st.attempts_remaining - 8'd1
                                                        : 8'd0;
  assign is_read = (st.current_function == mmrf_pkg::FC_READ_HOLD) ||
                   (st.current_function == mmrf_pkg::FC_READ_INPUT);

  // One item: next state and its single result word.
  always_comb begin
    st_next            = st;
    res.status         = mmrf_pkg::ST_NONE;
    res.byte_index     = '0;
    res.byte_value     = '0;

    unique case (cmd)
      mmrf_pkg::CMD_START: begin
        st_next.current_function   = function_code;
        st_next.attempts_remaining = cfg.retry_limit;
        st_next.frame_done         = 1'b0;
        st_next.elapsed_ticks      = '0;
        st_next.byte_count         = '0;
        st_next.needed_count       = mmrf_pkg::NEED_UNKNOWN;
        if (cfg.retry_limit == 8'd0) begin
          st_next.waiting = 1'b0;
          res.status      = mmrf_pkg::ST_FAILED;
        end else begin
          st_next.waiting = 1'b1;
          res.status      = mmrf_pkg::ST_SEND;
        end
      end

      mmrf_pkg::CMD_BYTE: begin
        if (st.waiting && !st.frame_done) begin
          res.status         = mmrf_pkg::ST_STORED;
          res.byte_index     = st.byte_count;
          res.byte_value     = rx_byte;
          st_next.byte_count = cnt_inc;
          if (cnt_inc > 9'd3) begin
            // Payload and trailer bytes: look for the end of the frame.
            if (cnt_inc == st.needed_count) begin
              st_next.frame_done = 1'b1;
              st_next.waiting    = 1'b0;
              res.status         = mmrf_pkg::ST_DONE;
            end else if (cnt_inc > st.needed_count ||
                         cnt_inc >= mmrf_pkg::MAX_FRAME_IDX) begin
              st_next.byte_count   = '0;
              st_next.needed_count = mmrf_pkg::NEED_UNKNOWN;
            end
          end else if (cnt_inc == 9'd3) begin
            // Byte count of a read reply sets the frame length.
            if (is_read) begin
              st_next.needed_count = read_len;
              if (read_len > mmrf_pkg::MAX_FRAME_IDX) begin
                st_next.byte_count = '0;
              end
            end
          end else if (cnt_inc == 9'd2) begin
            // Function code echo.
            if (rx_byte != st.current_function) begin
              st_next.byte_count = '0;
            end else if (st.current_function == mmrf_pkg::FC_WRITE_MULTI) begin
              st_next.needed_count = mmrf_pkg::WRITE_REPLY_LEN;
            end
          end else begin
            // Slave address.
            if (rx_byte != cfg.slave_address) begin
              st_next.byte_count = '0;
            end
          end
        end
      end

      mmrf_pkg::CMD_TICK: begin
        if (st.waiting && !st.frame_done) begin
          st_next.elapsed_ticks = elapsed_inc;
          if (elapsed_inc > cfg.timeout_ticks) begin
            st_next.attempts_remaining = attempts_dec;
            st_next.elapsed_ticks      = '0;
            st_next.byte_count         = '0;
            st_next.needed_count       = mmrf_pkg::NEED_UNKNOWN;
            if (attempts_dec == 8'd0) begin
              st_next.waiting = 1'b0;
              res.status      = mmrf_pkg::ST_FAILED;
            end else begin
              res.status      = mmrf_pkg::ST_RESEND;
            end
          end
        end
      end

      default: begin
      end
    endcase

    res.attempts_left = st_next.attempts_remaining;
  end

endmodule

// ----- rtl/core/modbus_master_response_framer.sv -----
// Master-side reply receiver for a serial register protocol. Each input word
// (start, received byte or time tick) yields exactly one result word: a request
// to send, a stored reply byte with its index, frame complete, resend after a
// timeout, failure or none, always with the attempts left. A word is accepted
// every clock cycle while result words are taken. Each word passes through the
// input register, and the result register takes its result when it is free or
// draining. While a result word is stalled, one more word is taken into the
// input register and then in_ready falls. The transaction state is updated
// once per word.
module modbus_master_response_framer (
  input  logic        clk,
  input  logic        rst,
  // Configuration writes.
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Input words.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  function_code,
  input  logic [7:0]  rx_byte,
  // Result words.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [8:0]  byte_index,
  output logic [7:0]  byte_value,
  output logic [7:0]  attempts_left
);

  mmrf_pkg::cfg_t    cfg;
  mmrf_pkg::state_t  st;
  mmrf_pkg::state_t  st_next;
  mmrf_pkg::result_t res;
  mmrf_pkg::result_t res_q;

  logic       in_q_valid;
  logic [1:0] in_q_cmd;
  logic [7:0] in_q_function_code;
  logic [7:0] in_q_rx_byte;
  logic       advance;

  // A registered word moves on when the result register is free or draining.
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address <= 8'd0;
      cfg.retry_limit   <= 8'd3;
      cfg.timeout_ticks <= 16'd3;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mmrf_pkg::REG_SLAVE_ADDRESS: cfg.slave_address <= cfg_data[7:0];
        mmrf_pkg::REG_RETRY_LIMIT:   cfg.retry_limit   <= cfg_data[7:0];
        mmrf_pkg::REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_cmd           <= cmd;
      in_q_function_code <= function_code;
      in_q_rx_byte       <= rx_byte;
    end
  end

  // Per-word state update.
  mmrf_step u_step (
    .cfg           (cfg),
    .st            (st),
    .cmd           (in_q_cmd),
    .function_code (in_q_function_code),
    .rx_byte       (in_q_rx_byte),
    .st_next       (st_next),
    .res           (res)
  );

  // Transaction state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.waiting            <= 1'b0;
      st.frame_done         <= 1'b0;
      st.byte_count         <= '0;
      st.needed_count       <= mmrf_pkg::NEED_UNKNOWN;
      st.current_function   <= 8'd0;
      st.elapsed_ticks      <= '0;
      st.attempts_remaining <= 8'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign status        = res_q.status;
  assign byte_index    = res_q.byte_index;
  assign byte_value    = res_q.byte_value;
  assign attempts_left = res_q.attempts_left;

endmodule

// ----- rtl/core/mmrf_checker.sv -----
module mmrf_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [8:0] byte_index,
  input logic [7:0] byte_value,
  input logic [7:0] attempts_left
);

  // Index and value are only carried with stored bytes.
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mmrf_pkg::ST_STORED && status != mmrf_pkg::ST_DONE
    |-> byte_index == 9'd0 && byte_value == 8'd0)
    else $error("index or value set on a word without a stored byte");

  // No byte is ever stored at or past the frame bound.
  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == mmrf_pkg::ST_STORED || status == mmrf_pkg::ST_DONE)
    |-> byte_index < mmrf_pkg::MAX_FRAME_IDX)
    else $error("stored byte index beyond frame bound");

  // Failure leaves no attempts; a send or resend always has one left.
  a_attempts: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mmrf_pkg::ST_FAILED |-> attempts_left == 8'd0)
    else $error("failure reported with attempts left");

  a_attempts_live: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == mmrf_pkg::ST_SEND || status == mmrf_pkg::ST_RESEND)
    |-> attempts_left != 8'd0)
    else $error("request issued with no attempts left");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready
    |=> out_valid && $stable(status) && $stable(byte_index) && $stable(byte_value)
        && $stable(attempts_left))
    else $error("result word changed while stalled");

endmodule

bind modbus_master_response_framer mmrf_checker u_mmrf_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .byte_index    (byte_index),
  .byte_value    (byte_value),
  .attempts_left (attempts_left)
);
